// ===== hdl/pcmaaf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmaaf_pkg
// shared types and constants of the pcm / aaf sample converter
// ----------------------------------------------------------------------------
`default_nettype none

package pcmaaf_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned BYTES_W    = 3;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_BYTES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH_MODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_BIG_ENDIAN = 2'd3;

  // bit depth codes
  localparam logic [2:0] DEPTH_16 = 3'd0;
  localparam logic [2:0] DEPTH_18 = 3'd1;
  localparam logic [2:0] DEPTH_20 = 3'd2;
  localparam logic [2:0] DEPTH_24 = 3'd3;
  localparam logic [2:0] DEPTH_32 = 3'd4;

  // direction codes
  localparam logic DIR_TX = 1'b0;
  localparam logic DIR_RX = 1'b1;

  // reset values
  localparam logic [2:0] HOST_BYTES_RST = 3'd2;

  typedef struct packed {
    logic       direction;
    logic [2:0] host_bytes;
    logic [2:0] bit_depth_mode;
    logic       host_big_endian;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic [BYTES_W-1:0]  out_bytes;
    logic                format_error;
    logic                last_out;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/pcmaaf_in_if.sv =====
// ----------------------------------------------------------------------------
// pcmaaf_in_if
// input sample channel: valid / ready with one sample per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface pcmaaf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_in;
  logic [2:0]  net_bytes;
  logic        last_in;

  modport source (output valid, output sample_in, output net_bytes, output last_in,
                  input ready);
  modport sink   (input valid, input sample_in, input net_bytes, input last_in,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/pcmaaf_out_if.sv =====
// ----------------------------------------------------------------------------
// pcmaaf_out_if
// result channel: valid / ready with one converted sample per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface pcmaaf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_out;
  logic [2:0]  out_bytes;
  logic        format_error;
  logic        last_out;

  modport source (output valid, output sample_out, output out_bytes,
                  output format_error, output last_out, input ready);
  modport sink   (input valid, input sample_out, input out_bytes,
                  input format_error, input last_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/pcmaaf_convert.sv =====
// ----------------------------------------------------------------------------
// pcmaaf_convert
// combinational byte gather, shift, sign extension and byte scatter
// ----------------------------------------------------------------------------
`default_nettype none

module pcmaaf_convert (
  input  wire pcmaaf_pkg::cfg_t cfg,
  input  wire logic [31:0]      sample_in,
  input  wire logic [2:0]       net_bytes,
  input  wire logic             last_in,
  output pcmaaf_pkg::res_t      res
);
  import pcmaaf_pkg::*;

  // assemble n bytes, byte 0 most significant when msb_first
  function automatic logic [31:0] gather(input logic [31:0] w, input logic [2:0] n,
                                         input logic msb_first);
    logic [31:0] v;
    v = '0;
    case (n)
      3'd1:    v = {24'd0, w[7:0]};
      3'd2:    v = msb_first ? {16'd0, w[7:0], w[15:8]} : {16'd0, w[15:0]};
      3'd3:    v = msb_first ? {8'd0, w[7:0], w[15:8], w[23:16]} : {8'd0, w[23:0]};
      3'd4:    v = msb_first ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
      default: v = '0;
    endcase
    return v;
  endfunction

  // emit the low n bytes, most significant first when msb_first
  function automatic logic [31:0] scatter(input logic [31:0] v, input logic [2:0] n,
                                          input logic msb_first);
    logic [31:0] o;
    o = '0;
    case (n)
      3'd1:    o = {24'd0, v[7:0]};
      3'd2:    o = msb_first ? {16'd0, v[7:0], v[15:8]} : {16'd0, v[15:0]};
      3'd3:    o = msb_first ? {8'd0, v[7:0], v[15:8], v[23:16]} : {8'd0, v[23:0]};
      3'd4:    o = msb_first ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
      default: o = '0;
    endcase
    return o;
  endfunction

  logic        cfg_ok;
  logic        nb_ok;
  logic        err;
  logic [2:0]  dshift;
  logic [2:0]  net_w;
  logic [2:0]  ref_bytes;
  logic [6:0]  sh;
  logic [6:0]  sh_neg;
  logic [31:0] tx_word;
  logic [31:0] rx_raw;
  logic [31:0] rx_shifted;
  logic [31:0] rx_word;
  logic [31:0] conv_data;
  logic [2:0]  conv_cnt;

  always_comb begin
    case (cfg.bit_depth_mode)
      DEPTH_16:           cfg_ok = (cfg.host_bytes == 3'd2);
      DEPTH_18, DEPTH_20: cfg_ok = (cfg.host_bytes == 3'd3);
      DEPTH_24:           cfg_ok = (cfg.host_bytes inside {3'd3, 3'd4});
      DEPTH_32:           cfg_ok = (cfg.host_bytes == 3'd4);
      default:            cfg_ok = 1'b0;
    endcase

    case (cfg.bit_depth_mode)
      DEPTH_18: dshift = 3'd6;
      DEPTH_20: dshift = 3'd4;
      default:  dshift = 3'd0;
    endcase

    case (cfg.bit_depth_mode)
      DEPTH_16: net_w = 3'd2;
      DEPTH_32: net_w = 3'd4;
      default:  net_w = 3'd3;
    endcase
  end

  assign nb_ok = (net_bytes inside {[3'd2:3'd4]});
  assign err   = !cfg_ok || ((cfg.direction == DIR_RX) && !nb_ok);

  // transmit: host container to big-endian network bytes
  assign tx_word = gather(sample_in, cfg.host_bytes, cfg.host_big_endian) << dshift;

  // receive: signed shift of -16..16, positive means right
  assign ref_bytes = ((cfg.host_bytes == 3'd4) && (cfg.bit_depth_mode == DEPTH_24))
                     ? 3'd3 : cfg.host_bytes;
  assign sh        = {1'b0, net_bytes, 3'b000} - {1'b0, ref_bytes, 3'b000}
                     + {4'd0, dshift};
  assign sh_neg    = 7'd0 - sh;
  assign rx_raw    = gather(sample_in, net_bytes, 1'b1);

  always_comb begin
    if (!sh[6]) begin
      rx_shifted = rx_raw >> sh[4:0];
    end else begin
      rx_shifted = rx_raw << sh_neg[4:0];
    end
    rx_word = rx_shifted;
    if ((cfg.host_bytes == 3'd4) && (net_bytes == 3'd3) && rx_shifted[23]) begin
      rx_word = rx_shifted | 32'hFF00_0000;
    end
  end

  always_comb begin
    if (cfg.direction == DIR_TX) begin
      conv_data = scatter(tx_word, net_w, 1'b1);
      conv_cnt  = net_w;
    end else begin
      conv_data = scatter(rx_word, cfg.host_bytes, cfg.host_big_endian);
      conv_cnt  = cfg.host_bytes;
    end

    res.last_out     = last_in;
    res.format_error = err;
    res.sample_out   = err ? '0 : conv_data;
    res.out_bytes    = err ? '0 : conv_cnt;
  end

endmodule

`default_nettype wire

// ===== hdl/pcm_aaf_sample_converter_core.sv =====
// ----------------------------------------------------------------------------
// pcm_aaf_sample_converter_core
// pcm sample converter between host containers and big-endian aaf samples
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake     payload
//  in_chan   sink       valid/ready   sample_in, net_bytes, last_in
//  out_chan  source     valid/ready   sample_out, out_bytes, format_error, last_out
//  cfg_*     sink       write enable  cfg_index, cfg_wdata
//
//  one beat per clock while the sink keeps up; the input register feeds the result
//  register with the conversion logic in between
//  reset clears both stage valids and loads the default configuration
//  a result held by a stalled sink does not stop the input register taking
//  one more beat; the input side stalls only when both stages are full
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_aaf_sample_converter_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  pcmaaf_in_if.sink                                 in_chan,
  pcmaaf_out_if.source                              out_chan,
  input  wire logic                                 cfg_we,
  input  wire logic [pcmaaf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcmaaf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pcmaaf_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  // input stage
  logic        s1_valid_r;
  logic [31:0] s1_sample_r;
  logic [2:0]  s1_nb_r;
  logic        s1_last_r;

  // result stage
  logic        out_valid_r;
  res_t        out_res_r;

  res_t        conv_res;
  logic        out_free;
  logic        s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction       <= DIR_TX;
      cfg_r.host_bytes      <= HOST_BYTES_RST;
      cfg_r.bit_depth_mode  <= DEPTH_16;
      cfg_r.host_big_endian <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION:       cfg_r.direction       <= cfg_wdata[0];
        CFG_HOST_BYTES:      cfg_r.host_bytes      <= cfg_wdata;
        CFG_BIT_DEPTH_MODE:  cfg_r.bit_depth_mode  <= cfg_wdata;
        CFG_HOST_BIG_ENDIAN: cfg_r.host_big_endian <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // a stage may load when empty or when its contents move on this cycle
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_free       = !s1_valid_r || out_free;
  assign in_chan.ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_chan.valid) begin
      s1_sample_r <= in_chan.sample_in;
      s1_nb_r     <= in_chan.net_bytes;
      s1_last_r   <= in_chan.last_in;
    end
  end

  pcmaaf_convert u_convert (
    .cfg       (cfg_r),
    .sample_in (s1_sample_r),
    .net_bytes (s1_nb_r),
    .last_in   (s1_last_r),
    .res       (conv_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_res_r <= conv_res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sample_out   = out_res_r.sample_out;
  assign out_chan.out_bytes    = out_res_r.out_bytes;
  assign out_chan.format_error = out_res_r.format_error;
  assign out_chan.last_out     = out_res_r.last_out;

endmodule

`default_nettype wire

// ===== tb/pcm_aaf_sample_converter_core_test.sv =====
// ----------------------------------------------------------------------------
// pcm_aaf_sample_converter_core_test
// self-checking bench for the pcm / aaf sample converter: directed corners of
// both directions and bad formats, then random streams over many settings,
// with random gaps on both channels and one long result-side stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_aaf_sample_converter_core_test;
  import pcmaaf_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_IDLE      = 13;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTED   = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pcmaaf_in_if  in_bus ();
  pcmaaf_out_if out_bus ();

  pcm_aaf_sample_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // our own copy of the converter settings, updated as registers are written
  cfg_t core_cfg;

  // converted samples still owed by the core, oldest first
  res_t converted_q[$];

  int   mismatch_count;
  int   result_beats;
  int   cycle_count;

  // pacing knobs shared with the sender task and the sink process
  bit   src_idle_on;
  bit   sink_idle_on;
  int   sink_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // assemble n bytes of a word, byte 0 most significant when msb_first
  function automatic logic [31:0] gather_bytes(logic [31:0] word, int n, bit msb_first);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < n && i < 4; i++) begin
      if (msb_first)
        acc = (acc << 8) | {24'd0, word[i*8 +: 8]};
      else
        acc[i*8 +: 8] = word[i*8 +: 8];
    end
    return acc;
  endfunction

  // lay out the low n bytes of a value in memory order
  function automatic logic [31:0] scatter_bytes(logic [31:0] value, int n, bit msb_first);
    logic [31:0] acc;
    int          src;
    acc = '0;
    for (int i = 0; i < n && i < 4; i++) begin
      src = msb_first ? (n - 1 - i) : i;
      acc[i*8 +: 8] = value[src*8 +: 8];
    end
    return acc;
  endfunction

  function automatic res_t convert_sample(logic [31:0] sample, logic [2:0] nb, logic last);
    res_t        r;
    logic [31:0] v;
    int          hb;
    int          nbi;
    int          dshift;
    int          ref_bytes;
    int          sh;
    int          cnt;
    bit          pair_ok;
    hb  = int'(core_cfg.host_bytes);
    nbi = int'(nb);
    r.last_out     = last;
    r.sample_out   = '0;
    r.out_bytes    = '0;
    r.format_error = 1'b1;
    case (core_cfg.bit_depth_mode)
      DEPTH_16:           pair_ok = (hb == 2);
      DEPTH_18, DEPTH_20: pair_ok = (hb == 3);
      DEPTH_24:           pair_ok = (hb == 3 || hb == 4);
      DEPTH_32:           pair_ok = (hb == 4);
      default:            pair_ok = 1'b0;
    endcase
    // 18 and 20 bit samples sit left-justified in the network container
    if (core_cfg.bit_depth_mode == DEPTH_18)
      dshift = 6;
    else if (core_cfg.bit_depth_mode == DEPTH_20)
      dshift = 4;
    else
      dshift = 0;
    if (!pair_ok || (core_cfg.direction == DIR_RX && (nbi < 2 || nbi > 4)))
      return r;
    if (core_cfg.direction == DIR_TX) begin
      v = gather_bytes(sample, hb, core_cfg.host_big_endian) << dshift;
      if (core_cfg.bit_depth_mode == DEPTH_16)
        cnt = 2;
      else if (core_cfg.bit_depth_mode == DEPTH_32)
        cnt = 4;
      else
        cnt = 3;
      r.sample_out = scatter_bytes(v, cnt, 1'b1);
    end else begin
      ref_bytes = (hb == 4 && core_cfg.bit_depth_mode == DEPTH_24) ? 3 : hb;
      sh = (nbi - ref_bytes) * 8 + dshift;
      v  = gather_bytes(sample, nbi, 1'b1);
      if (sh > 0)
        v = v >> sh;
      else
        v = v << (-sh);
      // 3-byte network samples into a 4-byte container get sign extended
      if (hb == 4 && nbi == 3 && v[23])
        v[31:24] = 8'hFF;
      cnt = hb;
      r.sample_out = scatter_bytes(v, cnt, core_cfg.host_big_endian);
    end
    r.out_bytes    = cnt[2:0];
    r.format_error = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one sample beat, after a random gap when src_idle_on, then log what it must become
  task automatic send_sample(logic [31:0] sample, logic [2:0] nb, logic last);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= sample;
    in_bus.net_bytes <= nb;
    in_bus.last_in   <= last;
    do @(posedge clk); while (!in_bus.ready);
    converted_q.push_back(convert_sample(sample, nb, last));
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_core();
    in_bus.valid <= 1'b0;
    while (converted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back while the core is idle
  task automatic load_config(logic dir, logic [2:0] hb, logic [2:0] mode, logic be);
    logic [CFG_IDX_W-1:0]  reg_idx[4];
    logic [CFG_DATA_W-1:0] reg_val[4];
    reg_idx = '{CFG_DIRECTION, CFG_HOST_BYTES, CFG_BIT_DEPTH_MODE, CFG_HOST_BIG_ENDIAN};
    reg_val = '{{2'b00, dir}, hb, mode, {2'b00, be}};
    drain_core();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_wdata <= reg_val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    core_cfg.direction       = dir;
    core_cfg.host_bytes      = hb;
    core_cfg.bit_depth_mode  = mode;
    core_cfg.host_big_endian = be;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch at result beat %0d: %s got %h want %h", result_beats, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // straight out of reset: transmit, 2-byte little-endian host, 16 bit
  task automatic test_reset_defaults();
    send_sample(32'h0000_0000, 3'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 3'd7, 1'b1);
  endtask

  // transmit depths 18, 20, 24 and 32, both host byte orders; net_bytes must be ignored
  task automatic test_transmit_formats();
    load_config(DIR_TX, 3'd3, DEPTH_18, 1'b1);
    send_sample(32'h00FF_FFFF, 3'd0, 1'b0);
    load_config(DIR_TX, 3'd3, DEPTH_20, 1'b0);
    send_sample(32'h1234_5678, 3'd5, 1'b1);
    load_config(DIR_TX, 3'd4, DEPTH_24, 1'b1);
    send_sample(32'h89AB_CDEF, 3'd2, 1'b0);
    load_config(DIR_TX, 3'd4, DEPTH_32, 1'b0);
    send_sample(32'hF00D_8001, 3'd7, 1'b1);
  endtask

  // receive: right and left shifts, sign extension of 3 into 4 bytes
  task automatic test_receive_formats();
    load_config(DIR_RX, 3'd4, DEPTH_24, 1'b1);
    send_sample(32'h0012_3480, 3'd3, 1'b0);   // top bit set, extends
    send_sample(32'h7856_3412, 3'd4, 1'b0);
    send_sample(32'hFFFF_0080, 3'd2, 1'b1);
    load_config(DIR_RX, 3'd4, DEPTH_32, 1'b0);
    send_sample(32'h00FF_80FF, 3'd3, 1'b0);   // extension even at 32 bit depth
    send_sample(32'hFFFF_FFFF, 3'd4, 1'b1);
    load_config(DIR_RX, 3'd3, DEPTH_18, 1'b1);
    send_sample(32'hFFFF_FFFF, 3'd2, 1'b0);
    send_sample(32'h8001_C0FF, 3'd4, 1'b0);
    load_config(DIR_RX, 3'd2, DEPTH_16, 1'b0);
    send_sample(32'hDEAD_BEEF, 3'd4, 1'b1);
  endtask

  // bad network widths and bad host / depth pairs all give the error beat
  task automatic test_bad_formats();
    load_config(DIR_RX, 3'd3, DEPTH_24, 1'b0);
    send_sample(32'h1122_3344, 3'd0, 1'b1);
    send_sample(32'h5566_7788, 3'd1, 1'b0);
    send_sample(32'h99AA_BBCC, 3'd5, 1'b1);
    send_sample(32'hFFFF_FFFF, 3'd7, 1'b0);
    load_config(DIR_TX, 3'd7, 3'd7, 1'b1);
    send_sample(32'hFFFF_FFFF, 3'd3, 1'b1);
    load_config(DIR_TX, 3'd0, DEPTH_16, 1'b0);
    send_sample(32'h0000_FFFF, 3'd2, 1'b0);
    load_config(DIR_RX, 3'd3, DEPTH_16, 1'b1);
    send_sample(32'hA5A5_5A5A, 3'd3, 1'b1);
  endtask

  // runs of random samples, each run under a freshly drawn setting
  task automatic test_random_streams();
    int         sent;
    int         run_len;
    logic [2:0] hb;
    logic [2:0] mode;
    logic [2:0] nb;
    sent = 0;
    while (sent < 750) begin
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 5))
          0:       begin mode = DEPTH_16; hb = 3'd2; end
          1:       begin mode = DEPTH_18; hb = 3'd3; end
          2:       begin mode = DEPTH_20; hb = 3'd3; end
          3:       begin mode = DEPTH_24; hb = 3'd3; end
          4:       begin mode = DEPTH_24; hb = 3'd4; end
          default: begin mode = DEPTH_32; hb = 3'd4; end
        endcase
      end else begin
        hb   = 3'($urandom_range(0, 7));
        mode = 3'($urandom_range(0, 7));
      end
      load_config(1'($urandom_range(0, 1)), hb, mode, 1'($urandom_range(0, 1)));
      // some runs go flat out on one side or both
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      run_len = $urandom_range(8, 40);
      repeat (run_len) begin
        nb = ($urandom_range(0, 7) != 0) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(0, 7));
        send_sample($urandom, nb, $urandom_range(0, 7) == 0);
        sent++;
      end
    end
  endtask

  // sink holds off for a long stretch while the source offers beats with no gaps
  task automatic test_backpressure();
    load_config(DIR_RX, 3'd4, DEPTH_24, 1'b0);
    src_idle_on      = 1'b0;
    sink_idle_on     = 1'b0;
    sink_hold_cycles = 200;
    repeat (30)
      send_sample($urandom, 3'($urandom_range(2, 4)), 1'($urandom_range(0, 1)));
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready pacing, checking, watchdog
  // ---------------------------------------------------------------------------

  // random per beat stall when sink_idle_on, or a long hold when the test asks
  initial begin : sink_pacing
    int stall;
    out_bus.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid && sink_hold_cycles == 0);
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      result_beats++;
      if (converted_q.size() == 0) begin
        report_mismatch("result beat with nothing owed", out_bus.sample_out, '0);
      end else begin
        want = converted_q.pop_front();
        if (out_bus.sample_out !== want.sample_out)
          report_mismatch("sample_out", out_bus.sample_out, want.sample_out);
        if (out_bus.out_bytes !== want.out_bytes)
          report_mismatch("out_bytes", 32'(out_bus.out_bytes), 32'(want.out_bytes));
        if (out_bus.format_error !== want.format_error)
          report_mismatch("format_error", 32'(out_bus.format_error), 32'(want.format_error));
        if (out_bus.last_out !== want.last_out)
          report_mismatch("last_out", 32'(out_bus.last_out), 32'(want.last_out));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_bus.valid     <= 1'b0;
    in_bus.sample_in <= '0;
    in_bus.net_bytes <= '0;
    in_bus.last_in   <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_DIRECTION;
    cfg_wdata        <= '0;
    rst_n            <= 1'b0;
    mismatch_count   = 0;
    result_beats     = 0;
    cycle_count      = 0;
    sink_hold_cycles = 0;
    src_idle_on      = 1'b1;
    sink_idle_on     = 1'b1;
    core_cfg.direction       = DIR_TX;
    core_cfg.host_bytes      = HOST_BYTES_RST;
    core_cfg.bit_depth_mode  = DEPTH_16;
    core_cfg.host_big_endian = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_transmit_formats();
    test_receive_formats();
    test_bad_formats();
    test_random_streams();
    test_backpressure();

    // everything owed must arrive, then the bench idles so that stray beats are caught
    drain_core();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
